// ----- rtl/scs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types, constants and tables for the sequence composition stats block.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int unsigned LEN_W   = 21;
	localparam logic [LEN_W-1:0] MAX_LEN = 21'd1048576;

	localparam int unsigned DIV_NW = 56;
	localparam int unsigned DIV_DW = 36;

	typedef enum logic [1:0] {
		MODE_DNA   = 2'd0,
		MODE_RNA   = 2'd1,
		MODE_AMINO = 2'd2,
		MODE_OTHER = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_GC = 2'd0,
		OP_TM = 2'd1,
		OP_NM = 2'd2,
		OP_MG = 2'd3
	} div_op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_LOAD = 2'd1,
		ST_RUN  = 2'd2,
		ST_EMIT = 2'd3
	} back_state_t;

	// Tm long rule, shifted so the dividend is never negative:
	// floor(N/D) = (N + K*D)/D - K with D = 20*tot
	localparam logic [41:0] TM_AT_STEP = 42'd3774998;
	localparam logic [41:0] TM_GC_STEP = 42'd3984918;
	localparam logic [41:0] TM_BIAS    = 42'd3442688;
	localparam logic [55:0] TM_K       = 56'd172135;
	localparam logic [55:0] NM_NUM     = 56'd65536000000;

	// snapshot of one finished sequence
	typedef struct packed {
		mode_t              mode;
		logic [LEN_W-1:0]   n;
		logic [LEN_W-1:0]   at;
		logic [LEN_W-1:0]   gc;
		logic [34:0]        gcw;
		logic [35:0]        mw_dna;
		logic [35:0]        mw_rna;
		logic [33:0]        ext;
		logic [41:0]        tmn;
		logic [24:0]        tmd;
		logic signed [35:0] pw;
		logic               sat;
	} rec_t;

	function automatic logic [14:0] residue_weight(input logic [7:0] s);
		logic [14:0] w;
		begin
			case (s)
				8'h41: w = 15'd8909;
				8'h42: w = 15'd13261;
				8'h43: w = 15'd12115;
				8'h44: w = 15'd13310;
				8'h45: w = 15'd14713;
				8'h46: w = 15'd16519;
				8'h47: w = 15'd7507;
				8'h48: w = 15'd15516;
				8'h49: w = 15'd13117;
				8'h4B: w = 15'd14619;
				8'h4C: w = 15'd13117;
				8'h4D: w = 15'd14921;
				8'h4E: w = 15'd13212;
				8'h50: w = 15'd11513;
				8'h51: w = 15'd14615;
				8'h52: w = 15'd17420;
				8'h53: w = 15'd10509;
				8'h54: w = 15'd11912;
				8'h56: w = 15'd11715;
				8'h57: w = 15'd20423;
				8'h59: w = 15'd18119;
				8'h5A: w = 15'd14664;
				default: w = 15'd0;
			endcase
			return w;
		end
	endfunction

endpackage

// ----- rtl/scs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_front
// Classifies characters and keeps running sums; snapshots them on last.
// ----------------------------------------------------------------------------
module scs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    symbol,
	input  logic          last,
	input  scs_pkg::mode_t mode,
	output logic          push,
	output scs_pkg::rec_t push_rec
);
	import scs_pkg::*;

	logic [LEN_W-1:0]   len_q, at_q, gc_q;
	logic [34:0]        gcw_q;
	logic [35:0]        mwd_q, mwr_q;
	logic [33:0]        ext_q;
	logic [41:0]        tmn_q;
	logic [24:0]        tmd_q;
	logic signed [35:0] pw_q;
	logic               sat_q;

	logic [LEN_W-1:0]   len_d, at_d, gc_d;
	logic [34:0]        gcw_d;
	logic [35:0]        mwd_d, mwr_d;
	logic [33:0]        ext_d;
	logic [41:0]        tmn_d;
	logic [24:0]        tmd_d;
	logic signed [35:0] pw_d;
	logic               sat_d;
	logic               is_a, is_c, is_g, is_tu, room;

	always_comb begin
		is_a  = (symbol == 8'h41);
		is_c  = (symbol == 8'h43);
		is_g  = (symbol == 8'h47);
		is_tu = (symbol == 8'h54) || (symbol == 8'h55);
		room  = (len_q < MAX_LEN);
		len_d = len_q; at_d = at_q; gc_d = gc_q; gcw_d = gcw_q;
		mwd_d = mwd_q; mwr_d = mwr_q; ext_d = ext_q;
		tmn_d = tmn_q; tmd_d = tmd_q; pw_d = pw_q;
		sat_d = sat_q | ~room;
		if (room) begin
			len_d = len_q + 1'b1;
			pw_d  = pw_q + $signed({21'd0, residue_weight(symbol)}) - 36'sd1800;
			if (is_a || is_tu) begin
				at_d  = at_q + 1'b1;
				tmn_d = tmn_q + TM_AT_STEP;
				tmd_d = tmd_q + 25'd20;
			end
			if (is_g || is_c) begin
				gc_d  = gc_q + 1'b1;
				gcw_d = gcw_q + 35'd25600;
				tmn_d = tmn_q + TM_GC_STEP;
				tmd_d = tmd_q + 25'd20;
			end
			if (is_a) begin
				mwd_d = mwd_q + 36'd31321; mwr_d = mwr_q + 36'd32921;
				ext_d = ext_q + 34'd15400;
			end
			if (is_tu) begin
				mwd_d = mwd_q + 36'd30420; mwr_d = mwr_q + 36'd30617;
				ext_d = ext_q + 34'd8800;
			end
			if (is_c) begin
				mwd_d = mwd_q + 36'd28918; mwr_d = mwr_q + 36'd30518;
				ext_d = ext_q + 34'd7300;
			end
			if (is_g) begin
				mwd_d = mwd_q + 36'd32921; mwr_d = mwr_q + 36'd34521;
				ext_d = ext_q + 34'd11700;
			end
		end
	end

	always_comb begin
		push              = accept && last;
		push_rec.mode     = mode;
		push_rec.n        = len_d;
		push_rec.at       = at_d;
		push_rec.gc       = gc_d;
		push_rec.gcw      = gcw_d;
		push_rec.mw_dna   = mwd_d + 36'd1704;
		push_rec.mw_rna   = mwr_d + 36'd15900;
		push_rec.ext      = ext_d;
		push_rec.tmn      = tmn_d - TM_BIAS;
		push_rec.tmd      = tmd_d;
		push_rec.pw       = pw_d + 36'sd1800;
		push_rec.sat      = sat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0; at_q <= '0; gc_q <= '0; gcw_q <= '0;
			mwd_q <= '0; mwr_q <= '0; ext_q <= '0;
			tmn_q <= '0; tmd_q <= '0; pw_q <= '0; sat_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				len_q <= '0; at_q <= '0; gc_q <= '0; gcw_q <= '0;
				mwd_q <= '0; mwr_q <= '0; ext_q <= '0;
				tmn_q <= '0; tmd_q <= '0; pw_q <= '0; sat_q <= 1'b0;
			end else begin
				len_q <= len_d; at_q <= at_d; gc_q <= gc_d; gcw_q <= gcw_d;
				mwd_q <= mwd_d; mwr_q <= mwr_d; ext_q <= ext_d;
				tmn_q <= tmn_d; tmd_q <= tmd_d; pw_q <= pw_d; sat_q <= sat_d;
			end
		end
	end

endmodule

// ----- rtl/scs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_queue
// Two-entry queue of sequence snapshots between front and back.
// ----------------------------------------------------------------------------
module scs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  scs_pkg::rec_t push_rec,
	input  logic          pop,
	output scs_pkg::rec_t pop_rec,
	output logic          empty,
	output logic          full
);
	import scs_pkg::*;

	rec_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign pop_rec = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ----- rtl/scs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [scs_pkg::DIV_NW-1:0] num,
	input  logic [scs_pkg::DIV_DW-1:0] den,
	output logic                       done,
	output logic [scs_pkg::DIV_NW-1:0] quo,
	output logic [scs_pkg::DIV_DW-1:0] rem
);
	import scs_pkg::*;

	localparam int unsigned CW = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] rem_q, den_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = num_q;
	assign rem   = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[DIV_NW-2:0], fits};
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start)             cnt_q <= CW'(DIV_NW);
			else if (cnt_q != '0)  cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/scs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_back
// Takes snapshots from the queue, runs the four divisions, emits one result.
// ----------------------------------------------------------------------------
module scs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  scs_pkg::rec_t q_rec,
	output logic          q_pop,
	output logic          result_valid,
	output logic [20:0]   seq_length,
	output logic [14:0]   gc_percent,
	output logic [35:0]   molar_weight,
	output logic [33:0]   ext_coef,
	output logic signed [18:0] melting_tm,
	output logic [23:0]   nmole_od260,
	output logic [22:0]   mg_od260,
	output logic signed [35:0] protein_weight,
	output logic          div_zero,
	output logic          overflow
);
	import scs_pkg::*;

	back_state_t state_q, state_d;
	div_op_t     op_q;
	rec_t        rec_q;
	logic        div_start, div_done;
	logic [DIV_NW-1:0] div_num, div_quo, rnd;
	logic [DIV_DW-1:0] div_den, div_rem;
	logic [35:0] mw;
	logic [14:0] gcp_q;
	logic [18:0] tm_q;
	logic [23:0] nm_q;
	logic [22:0] mg_q;
	logic [LEN_W-1:0] tot;
	logic        nucleic, ld, tot_z, ext_z;

	assign mw      = (rec_q.mode == MODE_RNA) ? rec_q.mw_rna : rec_q.mw_dna;
	assign tot     = rec_q.at + rec_q.gc;
	assign nucleic = (rec_q.mode == MODE_DNA) || (rec_q.mode == MODE_RNA);
	assign ld      = (rec_q.n >= LEN_W'(15));
	assign tot_z   = (tot == '0);
	assign ext_z   = (rec_q.ext == '0);

	always_comb begin
		case (op_q)
			OP_GC: begin
				div_num = DIV_NW'(rec_q.gcw);
				div_den = DIV_DW'(rec_q.n);
			end
			OP_TM: begin
				div_num = DIV_NW'(rec_q.tmn);
				div_den = DIV_DW'(rec_q.tmd);
			end
			OP_NM: begin
				div_num = NM_NUM;
				div_den = DIV_DW'(rec_q.ext);
			end
			default: begin
				// 655360 = 2^19 + 2^17
				div_num = DIV_NW'({mw, 19'd0}) + DIV_NW'({mw, 17'd0});
				div_den = DIV_DW'(rec_q.ext);
			end
		endcase
	end

	scs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign rnd = div_quo + DIV_NW'({div_rem, 1'b0} >= {1'b0, div_den});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!q_empty) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_RUN;
			ST_RUN:  if (div_done) state_d = (op_q == OP_MG) ? ST_EMIT : ST_LOAD;
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == ST_IDLE) && !q_empty;
		div_start = (state_q == ST_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_GC;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= (state_q == ST_EMIT);
			if (q_pop) op_q <= OP_GC;
			else if (state_q == ST_RUN && div_done && op_q != OP_MG)
				op_q <= div_op_t'(op_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) rec_q <= q_rec;
		if (state_q == ST_RUN && div_done) begin
			case (op_q)
				OP_GC:   gcp_q <= rnd[14:0];
				OP_TM:   tm_q  <= 19'(div_quo - TM_K);
				OP_NM:   nm_q  <= rnd[23:0];
				default: mg_q  <= rnd[22:0];
			endcase
		end
		if (state_q == ST_EMIT) begin
			seq_length     <= rec_q.n;
			overflow       <= rec_q.sat;
			gc_percent     <= '0;
			molar_weight   <= '0;
			ext_coef       <= '0;
			melting_tm     <= '0;
			nmole_od260    <= '0;
			mg_od260       <= '0;
			protein_weight <= '0;
			div_zero       <= 1'b0;
			if (nucleic) begin
				gc_percent   <= (rec_q.n == '0) ? '0 : gcp_q;
				molar_weight <= mw;
				ext_coef     <= rec_q.ext;
				if (!ld)
					melting_tm <= $signed(19'({rec_q.at, 9'd0} + {rec_q.gc, 10'd0}));
				else if (!tot_z)
					melting_tm <= $signed(tm_q);
				nmole_od260  <= ext_z ? '0 : nm_q;
				mg_od260     <= ext_z ? '0 : mg_q;
				div_zero     <= (rec_q.n == '0) || (ld && tot_z) || ext_z;
			end else if (rec_q.mode == MODE_AMINO) begin
				protein_weight <= rec_q.pw;
			end
		end
	end

endmodule

// ----- rtl/sequence_composition_stats_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_composition_stats_top
// Composition, weight, extinction, Tm and OD260 figures of a character stream.
// Characters: one per cycle while busy is low; busy rises only while two finished sequences wait.
// Result: on the last character's transfer the snapshot is queued; the back end
// pops it and runs the four divisions on the one shared 56-step divider, each
// with a load state and a run state that ends on done, then an emit state. The
// back end takes one sequence at a time; one strobe per sequence.
// The receiver cannot stall. Reset clears all counts and selects DNA mode.
// ----------------------------------------------------------------------------
module sequence_composition_stats_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  symbol,
	input  logic        last,
	output logic        result_valid,
	output logic [20:0] seq_length,
	output logic [14:0] gc_percent,
	output logic [35:0] molar_weight,
	output logic [33:0] ext_coef,
	output logic signed [18:0] melting_tm,
	output logic [23:0] nmole_od260,
	output logic [22:0] mg_od260,
	output logic signed [35:0] protein_weight,
	output logic        div_zero,
	output logic        overflow
);
	import scs_pkg::*;

	mode_t mode_q;
	logic  accept, push, pop, empty, full;
	rec_t  push_rec, pop_rec;

	assign pready = 1'b1;
	assign prdata = {30'd0, mode_q};
	assign busy   = full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DNA;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			mode_q <= mode_t'(pwdata[1:0]);
		end
	end

	scs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.symbol   (symbol),
		.last     (last),
		.mode     (mode_q),
		.push     (push),
		.push_rec (push_rec)
	);

	scs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty),
		.full     (full)
	);

	scs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (empty),
		.q_rec          (pop_rec),
		.q_pop          (pop),
		.result_valid   (result_valid),
		.seq_length     (seq_length),
		.gc_percent     (gc_percent),
		.molar_weight   (molar_weight),
		.ext_coef       (ext_coef),
		.melting_tm     (melting_tm),
		.nmole_od260    (nmole_od260),
		.mg_od260       (mg_od260),
		.protein_weight (protein_weight),
		.div_zero       (div_zero),
		.overflow       (overflow)
	);

endmodule
